[src/ppt_pkg.sv]
`timescale 1ns / 1ps
package ppt_pkg;
   localparam int unsigned AddrWidth = 6;
   localparam int unsigned TimeWidth = 32;

   typedef enum logic [1:0] {
      CMD_SAMPLE  = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CODE_NA   = 2'd0,
      CODE_ONE  = 2'd1,
      CODE_TWO  = 2'd2,
      CODE_RSVD = 2'd3
   } code_type;

   typedef enum logic [2:0] {
      REG_THRESHOLD = 3'd0,
      REG_VEL_NUM   = 3'd1,
      REG_G_NUM     = 3'd2,
      REG_ACQ_EN    = 3'd3,
      REG_TIMEOUT   = 3'd4
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_FINISH,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic update;
      logic start_square;
      logic start_div;
      logic finish;
   } cmd_ctl_type;

   typedef struct packed {
      logic need_div;
      logic square_done;
      logic div_done;
   } status_type;

   localparam logic [7:0] TimeoutReset = 8'd50;
endpackage

[src/ppt_req_if.sv]
`timescale 1ns / 1ps
interface ppt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic        light;
   logic        switch_open;
   logic [31:0] time_stamp;
   logic        laser_active;
   modport source(output valid, cmd, light, switch_open, time_stamp, laser_active,
      input ready);
   modport sink(input valid, cmd, light, switch_open, time_stamp, laser_active,
      output ready);
endinterface

[src/ppt_rsp_if.sv]
`timescale 1ns / 1ps
interface ppt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] period_ticks;
   logic [31:0] velocity;
   logic [31:0] g_value;
   logic        data_point;
   logic        osc_done;
   logic [1:0]  swing_mode;
   logic [1:0]  direction;
   logic [1:0]  stop_status;
   logic        light_now;
   logic        at_origin;
   modport source(output valid, period_ticks, velocity, g_value, data_point, osc_done,
      swing_mode, direction, stop_status, light_now, at_origin, input ready);
   modport sink(input valid, period_ticks, velocity, g_value, data_point, osc_done,
      swing_mode, direction, stop_status, light_now, at_origin, output ready);
endinterface

[src/ppt_ctrl.sv]
`timescale 1ns / 1ps
module ppt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ppt_pkg::cmd_ctl_type ctl,
   input  ppt_pkg::status_type  status
);
   import ppt_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_UPDATE;
         ST_UPDATE: state_in = status.need_div ? ST_SQUARE : ST_OUTPUT;
         ST_SQUARE: if (status.square_done) state_in = ST_DIVIDE;
         ST_DIVIDE: if (status.div_done) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_OUTPUT;
         ST_OUTPUT: if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_UPDATE: begin
            ctl.update = 1'b1;
            ctl.start_square = status.need_div;
         end
         ST_SQUARE: ctl.start_div = status.square_done;
         ST_DIVIDE: ;
         ST_FINISH: ctl.finish = 1'b1;
         ST_OUTPUT: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ctl.update) else $error("accept without update");
endmodule

[src/ppt_dp.sv]
`timescale 1ns / 1ps
module ppt_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic [1:0]           req_cmd,
   input  logic                 req_light,
   input  logic                 req_switch_open,
   input  logic [ppt_pkg::TimeWidth-1:0] req_time_stamp,
   input  logic                 req_laser_active,
   input  logic                 cfg_we,
   input  ppt_pkg::reg_type     cfg_idx,
   input  logic [63:0]          cfg_data,
   output logic [31:0]          cfg_threshold,
   output logic [31:0]          cfg_vel_num,
   output logic [63:0]          cfg_g_num,
   output logic                 cfg_acq_en,
   output logic [7:0]           cfg_timeout,
   input  ppt_pkg::cmd_ctl_type ctl,
   output ppt_pkg::status_type  status,
   output logic [31:0]          period_ticks,
   output logic [31:0]          velocity,
   output logic [31:0]          g_value,
   output logic                 data_point,
   output logic                 osc_done,
   output logic [1:0]           swing_mode,
   output logic [1:0]           direction,
   output logic [1:0]           stop_status,
   output logic                 light_now,
   output logic                 at_origin
);
   import ppt_pkg::*;

   localparam logic [31:0] Max32 = 32'hFFFF_FFFF;

   logic [31:0] thr_ff, vnum_ff;
   logic [63:0] gnum_ff;
   logic        acq_ff;
   logic [7:0]  tmo_ff;

   logic [1:0]  cmd_ff;
   logic        lvl_ff, sw_ff, laser_ff;
   logic [TimeWidth-1:0] ts_ff, edge_ff;

   logic        last_ff, pend_ff, org_ff;
   logic [31:0] inew_ff, per_ff, vel_ff, g_ff;
   logic [1:0]  half_ff;
   code_type    mode_ff, dir_ff, stop_ff;
   logic [7:0]  move_ff;
   logic        osc_ff, dp_ff;
   logic        div_g_ff;

   logic [TimeWidth-1:0] diff, t_light;
   logic [32:0] sum;
   logic        edge_hit, dark, light_e, need_g, need_v;

   assign diff = ts_ff - edge_ff;
   assign edge_hit = cmd_ff == CMD_SAMPLE && lvl_ff != last_ff;
   assign dark = edge_hit && !pend_ff && !lvl_ff;
   assign light_e = edge_hit && !pend_ff && lvl_ff;
   assign t_light = diff;
   assign sum = {1'b0, diff} + {1'b0, inew_ff};

   // multicycle units
   logic [63:0] sq_ff, mcand_ff;
   logic [31:0] mplier_ff;
   logic [5:0]  sq_cnt_ff;
   logic        sq_busy_ff;
   logic [63:0] rem_ff, quo_ff, dvs_ff, dvd_ff;
   logic [6:0]  dv_cnt_ff;
   logic        dv_busy_ff;
   logic [64:0] rem_sh;

   logic [31:0] per_next;
   logic        osc_next, dp_next, vel_go;

   always_comb begin
      per_next = per_ff;
      osc_next = 1'b0;
      dp_next = 1'b0;
      vel_go = 1'b0;
      if (dark) begin
         if (diff != 0 && inew_ff != 0) begin
            if (diff >= thr_ff) per_next = diff;
            else if (inew_ff < thr_ff) per_next = sum[32] ? Max32 : sum[31:0];
         end
      end
      if (light_e) begin
         vel_go = t_light < thr_ff && t_light != 0 && mode_ff == CODE_TWO;
      end
   end

   logic [1:0] half_next;
   always_comb begin
      half_next = half_ff;
      if (dark && diff != 0 && inew_ff != 0) begin
         if (diff >= thr_ff) half_next = 2'd2;
         else if (inew_ff >= thr_ff) half_next = 2'd0;
         else half_next = half_ff + 2'd1;
      end
   end

   assign need_g = dark && half_next == 2'd2 && acq_ff;
   assign need_v = vel_go;
   assign status.need_div = need_g || need_v;
   assign status.square_done = !sq_busy_ff;
   assign status.div_done = !dv_busy_ff && dv_cnt_ff == 7'd0;
   assign rem_sh = {rem_ff, dvd_ff[63]};

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff <= req_cmd;
         lvl_ff <= req_light;
         sw_ff <= req_switch_open;
         ts_ff <= req_time_stamp;
         laser_ff <= req_laser_active;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0; vnum_ff <= '0; gnum_ff <= '0; acq_ff <= 1'b0; tmo_ff <= TimeoutReset;
         last_ff <= 1'b0; pend_ff <= 1'b1; edge_ff <= '0; inew_ff <= '0;
         per_ff <= '0; half_ff <= '0; mode_ff <= CODE_NA; dir_ff <= CODE_NA;
         stop_ff <= CODE_NA; move_ff <= TimeoutReset; vel_ff <= '0; g_ff <= '0;
         org_ff <= 1'b0; osc_ff <= 1'b0; dp_ff <= 1'b0; div_g_ff <= 1'b0;
         sq_busy_ff <= 1'b0; dv_busy_ff <= 1'b0; sq_cnt_ff <= '0; dv_cnt_ff <= '0;
      end else begin
         if (cfg_we) begin
            unique case (cfg_idx)
               REG_THRESHOLD: thr_ff <= cfg_data[31:0];
               REG_VEL_NUM:   vnum_ff <= cfg_data[31:0];
               REG_G_NUM:     gnum_ff <= cfg_data;
               REG_ACQ_EN:    acq_ff <= cfg_data[0];
               REG_TIMEOUT:   tmo_ff <= cfg_data[7:0];
               default: ;
            endcase
         end
         if (ctl.update) begin
            osc_ff <= 1'b0;
            dp_ff <= 1'b0;
            div_g_ff <= need_g;
            unique case (cmd_ff)
               CMD_SAMPLE: begin
                  org_ff <= !sw_ff;
                  if (edge_hit) begin
                     move_ff <= tmo_ff;
                     stop_ff <= CODE_ONE;
                     last_ff <= lvl_ff;
                     if (pend_ff && !lvl_ff) begin
                        pend_ff <= 1'b0;
                        edge_ff <= ts_ff;
                        half_ff <= 2'd0;
                     end else if (dark) begin
                        inew_ff <= diff;
                        edge_ff <= ts_ff;
                        per_ff <= per_next;
                        if (diff != 0 && inew_ff != 0) begin
                           if (diff >= thr_ff || inew_ff >= thr_ff) begin
                              mode_ff <= CODE_ONE;
                              dir_ff <= CODE_NA;
                           end else begin
                              mode_ff <= CODE_TWO;
                              dir_ff <= diff > inew_ff ? CODE_TWO : CODE_ONE;
                           end
                        end
                        if (half_next == 2'd2) begin
                           osc_ff <= 1'b1;
                           half_ff <= 2'd0;
                           dp_ff <= acq_ff;
                        end else begin
                           half_ff <= half_next;
                        end
                     end else if (light_e && !vel_go) begin
                        vel_ff <= '0;
                     end
                  end
               end
               CMD_TICK: begin
                  if (!laser_ff) begin
                     move_ff <= tmo_ff;
                     dir_ff <= CODE_NA;
                     mode_ff <= CODE_NA;
                     stop_ff <= tmo_ff == 8'd0 ? CODE_TWO : CODE_NA;
                  end else begin
                     if (move_ff != 8'd0) move_ff <= move_ff - 8'd1;
                     if (move_ff <= 8'd1) begin
                        stop_ff <= CODE_TWO;
                        dir_ff <= CODE_NA;
                        mode_ff <= CODE_NA;
                     end
                  end
               end
               CMD_RESTART: begin
                  pend_ff <= 1'b1;
                  mode_ff <= CODE_NA;
                  acq_ff <= 1'b0;
                  g_ff <= '0;
               end
               default: ;
            endcase
         end
         // square of period, shift and add
         if (ctl.start_square) begin
            sq_busy_ff <= need_g;
            sq_ff <= '0;
            mcand_ff <= {32'd0, per_next};
            mplier_ff <= per_next;
            sq_cnt_ff <= 6'd32;
         end else if (sq_busy_ff) begin
            if (mplier_ff[0]) sq_ff <= sq_ff + mcand_ff;
            mcand_ff <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
            sq_cnt_ff <= sq_cnt_ff - 6'd1;
            if (sq_cnt_ff == 6'd1) sq_busy_ff <= 1'b0;
         end
         // restoring divide, one bit per cycle
         if (ctl.start_div) begin
            dv_busy_ff <= 1'b1;
            dv_cnt_ff <= 7'd64;
            rem_ff <= '0;
            quo_ff <= '0;
            dvd_ff <= div_g_ff ? gnum_ff : {32'd0, vnum_ff};
            dvs_ff <= div_g_ff ? sq_ff : {32'd0, t_light};
         end else if (dv_busy_ff) begin
            dvd_ff <= dvd_ff << 1;
            if (rem_sh >= {1'b0, dvs_ff}) begin
               rem_ff <= 64'(rem_sh - {1'b0, dvs_ff});
               quo_ff <= {quo_ff[62:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[63:0];
               quo_ff <= {quo_ff[62:0], 1'b0};
            end
            dv_cnt_ff <= dv_cnt_ff - 7'd1;
            if (dv_cnt_ff == 7'd1) dv_busy_ff <= 1'b0;
         end
         if (ctl.finish) begin
            if (div_g_ff) begin
               g_ff <= (dvs_ff == 64'd0 || quo_ff[63:32] != 32'd0) ? Max32 : quo_ff[31:0];
            end else begin
               vel_ff <= quo_ff[63:32] != 32'd0 ? Max32 : quo_ff[31:0];
            end
         end
      end
   end

   assign cfg_threshold = thr_ff;
   assign cfg_vel_num = vnum_ff;
   assign cfg_g_num = gnum_ff;
   assign cfg_acq_en = acq_ff;
   assign cfg_timeout = tmo_ff;

   assign period_ticks = per_ff;
   assign velocity = vel_ff;
   assign g_value = g_ff;
   assign data_point = dp_ff;
   assign osc_done = osc_ff;
   assign swing_mode = mode_ff;
   assign direction = dir_ff;
   assign stop_status = stop_ff;
   assign light_now = last_ff;
   assign at_origin = org_ff;

   a_dp_osc: assert property (@(posedge clock) disable iff (reset)
      dp_ff |-> osc_ff) else $error("data point without oscillation");
   a_units: assert property (@(posedge clock) disable iff (reset)
      !(sq_busy_ff && dv_busy_ff)) else $error("square and divide overlap");
   a_half: assert property (@(posedge clock) disable iff (reset)
      osc_ff |-> half_ff == 2'd0) else $error("half count not cleared");
endmodule

[src/pendulum_photogate_timer.sv]
`timescale 1ns / 1ps
// Channel  Ports   Direction  Transaction
// request  req_*   in         cmd, light, switch_open, time_stamp, laser_active
// response rsp_*   out        period, velocity, g, pulses, status codes
// config   csr_*   in         APB write/read, 8-byte register stride
// An item without a division passes through accept, state update and result.
// g passes a 32-step shift-add square, then a 64-step divider.
// Velocity goes through the same divider, the square skipped.
// Synchronous active-high reset; no clearing pass.
// The request side is held off until the result transaction is taken.
module pendulum_photogate_timer (
   input  logic        clock,
   input  logic        reset,
   ppt_req_if.sink     req,
   ppt_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [ppt_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import ppt_pkg::*;

   cmd_ctl_type ctl;
   status_type  status;
   logic        cfg_we;
   reg_type     cfg_idx;
   logic [31:0] thr, vnum;
   logic [63:0] gnum;
   logic        acq;
   logic [7:0]  tmo;

   assign csr_pready = 1'b1;
   assign cfg_we = csr_psel && csr_penable && csr_pwrite;
   assign cfg_idx = reg_type'(csr_paddr[5:3]);

   always_comb begin
      unique case (cfg_idx)
         REG_THRESHOLD: csr_prdata = {32'd0, thr};
         REG_VEL_NUM:   csr_prdata = {32'd0, vnum};
         REG_G_NUM:     csr_prdata = gnum;
         REG_ACQ_EN:    csr_prdata = {63'd0, acq};
         REG_TIMEOUT:   csr_prdata = {56'd0, tmo};
         default:       csr_prdata = '0;
      endcase
   end

   ppt_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .ctl, .status
   );

   ppt_dp u_dp (
      .clock, .reset,
      .req_fire(req.valid && req.ready),
      .req_cmd(req.cmd), .req_light(req.light), .req_switch_open(req.switch_open),
      .req_time_stamp(req.time_stamp), .req_laser_active(req.laser_active),
      .cfg_we, .cfg_idx, .cfg_data(csr_pwdata),
      .cfg_threshold(thr), .cfg_vel_num(vnum), .cfg_g_num(gnum),
      .cfg_acq_en(acq), .cfg_timeout(tmo),
      .ctl, .status,
      .period_ticks(rsp.period_ticks), .velocity(rsp.velocity), .g_value(rsp.g_value),
      .data_point(rsp.data_point), .osc_done(rsp.osc_done), .swing_mode(rsp.swing_mode),
      .direction(rsp.direction), .stop_status(rsp.stop_status),
      .light_now(rsp.light_now), .at_origin(rsp.at_origin)
   );
endmodule

[dv/pendulum_photogate_timer_test.sv]
`timescale 1ns / 1ps
module pendulum_photogate_timer_test;
   import ppt_pkg::*;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        light;
      logic        switch_open;
      logic [31:0] time_stamp;
      logic        laser_active;
   } sample_type;

   typedef struct packed {
      logic [31:0] period_ticks;
      logic [31:0] velocity;
      logic [31:0] g_value;
      logic        data_point;
      logic        osc_done;
      logic [1:0]  swing_mode;
      logic [1:0]  direction;
      logic [1:0]  stop_status;
      logic        light_now;
      logic        at_origin;
   } reading_type;

   typedef struct packed {
      sample_type  stim;
      logic        known;
      reading_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [AddrWidth-1:0] csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic csr_pready;

   ppt_req_if req ();
   ppt_rsp_if rsp ();

   pendulum_photogate_timer dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor state
   logic [31:0] thr_reg, vnum_reg;
   logic [63:0] gnum_reg;
   logic        acq_reg;
   logic [7:0]  tout_reg;
   logic        lvl_q, pend_q, org_q;
   logic [31:0] edge_q, int_new, int_old, per_q, vel_q, g_q;
   logic [1:0]  half_q;
   code_type    mode_q, dir_q, stop_q;
   logic [7:0]  move_q;

   reading_type readings_due[$];
   int unsigned n_errors = 0, n_results = 0, n_osc = 0, n_points = 0, n_vel = 0;
   longint unsigned cycles = 0;
   logic rx_hold = 1'b0;
   logic rx_calm = 1'b0;
   logic tx_calm = 1'b0;
   logic stim_done = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd3_000_000) begin
         $display("timeout at %0t", $time);
         $display("pendulum_photogate_timer_test NOT OK");
         $finish;
      end
   end

   task automatic reset_predictor();
      thr_reg = '0; vnum_reg = '0; gnum_reg = '0; acq_reg = 1'b0; tout_reg = TimeoutReset;
      lvl_q = 1'b0; pend_q = 1'b1; org_q = 1'b0; edge_q = '0; int_new = '0; int_old = '0;
      per_q = '0; vel_q = '0; g_q = '0; half_q = '0; mode_q = CODE_NA; dir_q = CODE_NA;
      stop_q = CODE_NA; move_q = TimeoutReset;
   endtask

   function automatic logic [31:0] gravity_of(input logic [31:0] per);
      logic [63:0] sq, q;
      if (per == 0) return 32'hFFFF_FFFF;
      sq = 64'(per) * 64'(per);
      q = gnum_reg / sq;
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic reading_type predict_reading(input sample_type s);
      reading_type r;
      logic [31:0] t;
      logic [32:0] sum;
      logic dp, osc;
      dp = 1'b0; osc = 1'b0;
      case (cmd_type'(s.cmd))
         CMD_SAMPLE: begin
            org_q = ~s.switch_open;
            if (s.light != lvl_q) begin
               move_q = tout_reg;
               stop_q = CODE_ONE;
               lvl_q = s.light;
               if (pend_q && !s.light) begin
                  pend_q = 1'b0; edge_q = s.time_stamp; half_q = '0;
               end else if (!pend_q && !s.light) begin
                  int_old = int_new;
                  int_new = s.time_stamp - edge_q;
                  edge_q = s.time_stamp;
                  if (int_new != 0 && int_old != 0) begin
                     if (int_new >= thr_reg) begin
                        mode_q = CODE_ONE; per_q = int_new; dir_q = CODE_NA; half_q = 2'd2;
                     end else if (int_old >= thr_reg) begin
                        mode_q = CODE_ONE; dir_q = CODE_NA; half_q = '0;
                     end else begin
                        sum = 33'(int_new) + 33'(int_old);
                        mode_q = CODE_TWO;
                        per_q = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        half_q = half_q + 2'd1;
                        dir_q = (int_new > int_old) ? CODE_TWO : CODE_ONE;
                     end
                  end
                  if (half_q == 2'd2) begin
                     osc = 1'b1; half_q = '0;
                     if (acq_reg) begin
                        dp = 1'b1; g_q = gravity_of(per_q);
                     end
                  end
               end else if (!pend_q) begin
                  t = s.time_stamp - edge_q;
                  if (t < thr_reg && t != 0 && mode_q == CODE_TWO) vel_q = vnum_reg / t;
                  else vel_q = '0;
               end
            end
         end
         CMD_TICK: begin
            if (s.laser_active && move_q != 0) move_q = move_q - 8'd1;
            if (!s.laser_active) begin
               move_q = tout_reg; stop_q = CODE_NA; dir_q = CODE_NA; mode_q = CODE_NA;
            end
            if (move_q == 0) begin
               stop_q = CODE_TWO; dir_q = CODE_NA; mode_q = CODE_NA;
            end
         end
         CMD_RESTART: begin
            pend_q = 1'b1; mode_q = CODE_NA; acq_reg = 1'b0; g_q = '0;
         end
         default: ;
      endcase
      r.period_ticks = per_q; r.velocity = vel_q; r.g_value = g_q;
      r.data_point = dp; r.osc_done = osc; r.swing_mode = mode_q; r.direction = dir_q;
      r.stop_status = stop_q; r.light_now = lvl_q; r.at_origin = org_q;
      return r;
   endfunction

   // sender
   initial begin
      req.valid = 1'b0; req.cmd = CMD_SAMPLE; req.light = 1'b0; req.switch_open = 1'b0;
      req.time_stamp = '0; req.laser_active = 1'b0;
   end

   task automatic send_item(input sample_type s);
      while (!tx_calm && $urandom_range(0, 99) < 20) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1; req.cmd <= s.cmd; req.light <= s.light;
      req.switch_open <= s.switch_open; req.time_stamp <= s.time_stamp;
      req.laser_active <= s.laser_active;
      readings_due.push_back(predict_reading(s));
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic send_checked(input sample_type s, input reading_type want);
      reading_type got;
      got = predict_reading(s);
      readings_due.push_back(want);
      if (got != want) begin
         $display("%0t table row disagrees with predictor: expected %h actual %h",
                  $time, want, got);
         n_errors++;
      end
      while (!tx_calm && $urandom_range(0, 99) < 20) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1; req.cmd <= s.cmd; req.light <= s.light;
      req.switch_open <= s.switch_open; req.time_stamp <= s.time_stamp;
      req.laser_active <= s.laser_active;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic write_reg(input reg_type idx, input logic [63:0] val);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= AddrWidth'(idx) << 3; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_THRESHOLD: thr_reg = val[31:0];
         REG_VEL_NUM:   vnum_reg = val[31:0];
         REG_G_NUM:     gnum_reg = val;
         REG_ACQ_EN:    acq_reg = val[0];
         REG_TIMEOUT:   tout_reg = val[7:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (readings_due.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   function automatic sample_type mk(input cmd_type c, input logic l, input logic sw,
                                     input logic [31:0] ts, input logic las);
      sample_type s;
      s.cmd = c; s.light = l; s.switch_open = sw; s.time_stamp = ts; s.laser_active = las;
      return s;
   endfunction

   function automatic reading_type rd(input logic [31:0] p, input logic [31:0] v,
                                      input logic [31:0] g, input code_type m,
                                      input code_type d, input code_type st,
                                      input logic l, input logic o);
      reading_type r;
      r.period_ticks = p; r.velocity = v; r.g_value = g; r.data_point = 1'b0;
      r.osc_done = 1'b0; r.swing_mode = m; r.direction = d; r.stop_status = st;
      r.light_now = l; r.at_origin = o;
      return r;
   endfunction

   // n pendulum passes: light then dark, with random gaps near the threshold
   task automatic swing_burst(input int n, inout logic [31:0] ts);
      for (int i = 0; i < n; i++) begin
         ts = ts + $urandom_range(1, 300);
         send_item(mk(CMD_SAMPLE, 1'b1, $urandom_range(0, 1), ts, 1'b0));
         ts = ts + $urandom_range(1, 1200);
         send_item(mk(CMD_SAMPLE, 1'b0, $urandom_range(0, 1), ts, 1'b0));
         if ($urandom_range(0, 19) == 0)
            send_item(mk(CMD_TICK, 1'b0, 1'b0, $urandom, $urandom_range(0, 1)));
      end
   endtask

   task automatic random_item(inout logic [31:0] ts);
      sample_type s;
      s = sample_type'({$urandom, $urandom});
      if ($urandom_range(0, 3) != 0) s.cmd = CMD_SAMPLE;
      if ($urandom_range(0, 1)) begin
         ts = ts + $urandom_range(0, 1500); s.time_stamp = ts;
      end
      send_item(s);
   endtask

   row_type table_rows[$];
   initial begin
      logic [31:0] ts;
      reading_type r0;
      reset_predictor();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      r0 = rd(0, 0, 0, CODE_NA, CODE_NA, CODE_NA, 1'b0, 1'b0);
      table_rows.push_back({mk(CMD_NONE, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1), 1'b1, r0});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b0, 1'b0, 32'h0, 1'b0), 1'b1,
                            rd(0, 0, 0, CODE_NA, CODE_NA, CODE_NA, 1'b0, 1'b1)});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0), 1'b1,
                            rd(0, 0, 0, CODE_NA, CODE_NA, CODE_ONE, 1'b1, 1'b0)});
      table_rows.push_back({mk(CMD_TICK, 1'b0, 1'b0, 32'h0, 1'b0), 1'b1,
                            rd(0, 0, 0, CODE_NA, CODE_NA, CODE_NA, 1'b1, 1'b0)});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b0, 1'b1, 32'h10, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b1, 1'b0, 32'h20, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b0, 1'b0, 32'h40, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b1, 1'b0, 32'h50, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b0, 1'b0, 32'h90, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b1, 1'b0, 32'h95, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b0, 1'b0, 32'hC0, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b1, 1'b0, 32'hC1, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b0, 1'b0, 32'hFFFF_FFF0, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b1, 1'b0, 32'h5, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b0, 1'b0, 32'h5, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_TICK, 1'b0, 1'b0, 32'h0, 1'b1), 1'b0, r0});
      table_rows.push_back({mk(CMD_RESTART, 1'b0, 1'b0, 32'h0, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_SAMPLE, 1'b1, 1'b0, 32'h100, 1'b0), 1'b0, r0});
      table_rows.push_back({mk(CMD_NONE, 1'b0, 1'b0, 32'h0, 1'b0), 1'b0, r0});

      for (int i = 0; i < table_rows.size(); i++) begin
         if (i == 4) begin
            drain();
            write_reg(REG_THRESHOLD, 64'h60);
            write_reg(REG_VEL_NUM, 64'hFFFF_FFFF);
            write_reg(REG_G_NUM, 64'hFFFF_FFFF_FFFF_FFFF);
            write_reg(REG_ACQ_EN, 64'h1);
            write_reg(REG_TIMEOUT, 64'h0);
         end
         if (table_rows[i].known) send_checked(table_rows[i].stim, table_rows[i].want);
         else send_item(table_rows[i].stim);
      end
      drain();

      ts = $urandom;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_reg(REG_THRESHOLD, 64'd900); write_reg(REG_VEL_NUM, $urandom);
               write_reg(REG_G_NUM, {$urandom, $urandom}); write_reg(REG_ACQ_EN, 64'h1);
               write_reg(REG_TIMEOUT, 64'd255);
            end
            1: begin
               write_reg(REG_THRESHOLD, 64'hFFFF_FFFF); write_reg(REG_G_NUM, 64'd0);
               write_reg(REG_TIMEOUT, 64'd3);
            end
            2: begin
               write_reg(REG_THRESHOLD, 64'd0); write_reg(REG_VEL_NUM, 64'd0);
               write_reg(REG_TIMEOUT, 64'd0);
            end
            default: begin
               write_reg(REG_THRESHOLD, $urandom_range(200, 2000));
               write_reg(REG_VEL_NUM, $urandom);
               write_reg(REG_G_NUM, {$urandom, $urandom} >> $urandom_range(0, 40));
               write_reg(REG_ACQ_EN, $urandom_range(0, 1));
               write_reg(REG_TIMEOUT, $urandom_range(0, 255));
            end
         endcase
         tx_calm = (ph == 5);
         rx_calm = (ph == 5);
         rx_hold = (ph == 3);
         for (int k = 0; k < 52; k++) begin
            if ($urandom_range(0, 4) != 0) swing_burst($urandom_range(1, 3), ts);
            else random_item(ts);
            if (k == 2 && $urandom_range(0, 2) == 0)
               send_item(mk(CMD_RESTART, 1'b0, 1'b0, $urandom, 1'b0));
         end
         drain();
      end
      stim_done = 1'b1;
   end

   // long stall of the receiver
   initial begin
      int unsigned n;
      wait (rx_hold);
      n = 0;
      while (n < 400) begin
         @(posedge clock);
         n++;
      end
      rx_hold = 1'b0;
   end

   initial rsp.ready = 1'b0;
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (rx_hold) rsp.ready <= 1'b0;
      else rsp.ready <= rx_calm || ($urandom_range(0, 99) >= 20);
   end

   always @(posedge clock) begin
      reading_type want, got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.period_ticks = rsp.period_ticks; got.velocity = rsp.velocity;
         got.g_value = rsp.g_value; got.data_point = rsp.data_point;
         got.osc_done = rsp.osc_done; got.swing_mode = rsp.swing_mode;
         got.direction = rsp.direction; got.stop_status = rsp.stop_status;
         got.light_now = rsp.light_now; got.at_origin = rsp.at_origin;
         n_results++;
         if (got.osc_done) n_osc++;
         if (got.data_point) n_points++;
         if (got.velocity != 0) n_vel++;
         if (readings_due.size() == 0) begin
            $display("%0t unexpected transaction: actual %p", $time, got);
            n_errors++;
         end else begin
            want = readings_due.pop_front();
            if (got !== want) begin
               $display("%0t mismatch: expected %p", $time, want);
               $display("%0t            actual   %p", $time, got);
               n_errors++;
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      if (readings_due.size() != 0) n_errors++;
      $display("covered %0d transactions: %0d oscillations, %0d g points, %0d velocities",
               n_results, n_osc, n_points, n_vel);
      if (n_errors == 0) $display("pendulum_photogate_timer_test OK");
      else $display("pendulum_photogate_timer_test NOT OK");
      $finish;
   end
endmodule

[files.f]
src/ppt_pkg.sv
src/ppt_req_if.sv
src/ppt_rsp_if.sv
src/ppt_ctrl.sv
src/ppt_dp.sv
src/pendulum_photogate_timer.sv
dv/pendulum_photogate_timer_test.sv
